// ===== hw/rtl/opmt_pkg.sv =====
// opmt_pkg: sizes, action and status codes, cell command and candidate types
// for the ordered prefix match table; used by every module under hw/rtl
// no dependencies
package opmt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ENTRY_WIDTH = 32;
   localparam int LEN_W       = 6;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int GROUP_SIZE  = 8;

   // number of candidates left after a given number of tree levels
   function automatic int tree_width(int level);
      int n;
      n = TABLE_DEPTH;
      for (int l = 0; l < level; l++) begin
         n = (n + GROUP_SIZE - 1) / GROUP_SIZE;
      end
      return n;
   endfunction

   function automatic int tree_depth();
      int n;
      int d;
      n = TABLE_DEPTH;
      d = 0;
      while (n > 1) begin
         n = (n + GROUP_SIZE - 1) / GROUP_SIZE;
         d++;
      end
      return d;
   endfunction

   localparam int TREE_LEVELS = tree_depth();
   localparam int STEP_W      = $clog2(TREE_LEVELS + 1);

   localparam logic [2:0] ACT_SEARCH       = 3'd0;
   localparam logic [2:0] ACT_EXACT        = 3'd1;
   localparam logic [2:0] ACT_INSERT       = 3'd2;
   localparam logic [2:0] ACT_INSERT_SHIFT = 3'd3;
   localparam logic [2:0] ACT_REMOVE       = 3'd4;
   localparam logic [2:0] ACT_REMOVE_SHIFT = 3'd5;
   localparam logic [2:0] ACT_READ         = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_WIDE  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_SEARCH,
      CMD_EXACT,
      CMD_READ,
      CMD_WRITE,
      CMD_SHIFT_IN,
      CMD_APPEND,
      CMD_CLEAR,
      CMD_SHIFT_OUT
   } cmd_kind_type;

   typedef struct packed {
      logic [ENTRY_WIDTH-1:0] bits;
      logic [LEN_W-1:0]       len;
      logic                   valid;
   } slot_type;

   typedef struct packed {
      logic                   hit;
      logic [IDX_W-1:0]       index;
      logic [ENTRY_WIDTH-1:0] bits;
      logic [LEN_W-1:0]       len;
   } cand_type;

   // broadcast to every cell
   typedef struct packed {
      logic                   go;
      cmd_kind_type           kind;
      logic [IDX_W-1:0]       pos;
      logic [CNT_W-1:0]       count;
      logic [ENTRY_WIDTH-1:0] key;
      logic [LEN_W-1:0]       klen;
   } cmd_type;

   typedef struct packed {
      logic             is_read;
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
   } result_ctl_type;

   // leading len bits set, saturating at the full width
   function automatic logic [ENTRY_WIDTH-1:0] lead_mask(logic [LEN_W-1:0] len);
      return ~({ENTRY_WIDTH{1'b1}} >> len);
   endfunction

endpackage

// ===== hw/rtl/ordered_prefix_match_table.sv =====
// ordered_prefix_match_table: top level; decodes the action, drives the row
// of slot cells and reduces their hits through a registered priority tree
// depends on opmt_pkg, opmt_cell, opmt_pick
//
//   channel   direction   handshake            word
//   req_      in          req_valid/req_ready  action, key bits, key length, position
//   rsp_      out         rsp_valid/rsp_ready  hit, index, read entry, status, entries used
//
// one word at a time: the cells update and compare at the edge that accepts
// the word, then the levels of the priority tree register in turn, then the
// output register; no new word is taken until the result is in the output register
// reset clears the slot count and the handshake; slot contents start undefined
// a word may be accepted while the previous result waits on rsp_ready
module ordered_prefix_match_table import opmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_action,
   input  logic [ENTRY_WIDTH-1:0] req_key_bits,
   input  logic [LEN_W-1:0]       req_key_length,
   input  logic [IDX_W-1:0]       req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic [IDX_W-1:0]       rsp_match_index,
   output logic [ENTRY_WIDTH-1:0] rsp_read_bits,
   output logic [LEN_W-1:0]       rsp_read_length,
   output logic [1:0]             rsp_status,
   output logic [CNT_W-1:0]       rsp_entries_used
);

   logic              accept;
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_out;
   logic [CNT_W-1:0]  count_ff, count_in;
   result_ctl_type    ctl_ff, ctl_in;
   cmd_type           cmd;

   logic [CNT_W-1:0]  pos_c;
   logic              in_table;
   logic              too_wide;
   logic              no_room;
   cmd_kind_type      kind;
   logic [1:0]        status;

   logic                   hit_ff;
   logic [IDX_W-1:0]       index_ff;
   logic [ENTRY_WIDTH-1:0] rbits_ff;
   logic [LEN_W-1:0]       rlen_ff;

   slot_type slots [TABLE_DEPTH];
   cand_type leaf  [TABLE_DEPTH];
   cand_type tree_ff [1:TREE_LEVELS][TABLE_DEPTH];
   cand_type final_cand;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;

   // action decode against the current slot count
   always_comb begin
      pos_c    = CNT_W'(req_position);
      in_table = pos_c < count_ff;
      too_wide = 32'(req_key_length) > ENTRY_WIDTH;
      no_room  = in_table ? ((req_action == ACT_INSERT_SHIFT) &&
                             (count_ff >= CNT_W'(TABLE_DEPTH)))
                          : (pos_c >= CNT_W'(TABLE_DEPTH));
      kind     = CMD_IDLE;
      status   = ST_OK;
      count_in = count_ff;
      ctl_in.is_read = 1'b0;
      case (req_action)
         ACT_SEARCH: kind = CMD_SEARCH;
         ACT_EXACT:  kind = CMD_EXACT;
         ACT_INSERT, ACT_INSERT_SHIFT: begin
            if (no_room) begin
               status = ST_FULL;
            end else if (too_wide) begin
               status = ST_WIDE;
            end else if (in_table) begin
               if (req_action == ACT_INSERT_SHIFT) begin
                  kind     = CMD_SHIFT_IN;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  kind = CMD_WRITE;
               end
            end else begin
               kind     = CMD_APPEND;
               count_in = pos_c + CNT_W'(1);
            end
         end
         ACT_REMOVE: begin
            if (in_table) kind = CMD_CLEAR;
            else status = ST_RANGE;
         end
         ACT_REMOVE_SHIFT: begin
            if (in_table) begin
               kind     = CMD_SHIFT_OUT;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status = ST_RANGE;
            end
         end
         ACT_READ: begin
            ctl_in.is_read = 1'b1;
            if (in_table) kind = CMD_READ;
            else status = ST_RANGE;
         end
         default: ;
      endcase
      ctl_in.status = status;
      ctl_in.count  = count_in;

      cmd.go    = accept;
      cmd.kind  = kind;
      cmd.pos   = req_position;
      cmd.count = count_ff;
      cmd.key   = req_key_bits;
      cmd.klen  = req_key_length;
   end

   // row of slot cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      slot_type left_slot, right_slot;
      if (i == 0) begin : g_first
         assign left_slot = '0;
      end else begin : g_mid_l
         assign left_slot = slots[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_mid_r
         assign right_slot = slots[i+1];
      end
      opmt_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .cand       (leaf[i])
      );
   end

   // registered priority tree, lowest index wins
   for (genvar l = 1; l <= TREE_LEVELS; l++) begin : g_level
      for (genvar g = 0; g < tree_width(l); g++) begin : g_group
         cand_type grp [GROUP_SIZE];
         cand_type tree_in;
         for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_leg
            if (g * GROUP_SIZE + k >= tree_width(l - 1)) begin : g_none
               assign grp[k] = '0;
            end else if (l == 1) begin : g_leaf
               assign grp[k] = leaf[g * GROUP_SIZE + k];
            end else begin : g_node
               assign grp[k] = tree_ff[l-1][g * GROUP_SIZE + k];
            end
         end
         opmt_pick u_pick (
            .cand (grp),
            .best (tree_in)
         );
         always_ff @(posedge clock) begin
            tree_ff[l][g] <= tree_in;
         end
      end
   end

   assign final_cand = tree_ff[TREE_LEVELS][0];

   // sequencing: wait for the tree to settle and for the output word to be free, then hand over to it
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      load_out     = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff != STEP_W'(TREE_LEVELS)) begin
            step_in = step_ff + STEP_W'(1);
         end else if (!rsp_valid_ff || rsp_ready) begin
            load_out     = 1'b1;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) ctl_ff <= ctl_in;
      if (load_out) begin
         hit_ff   <= final_cand.hit;
         index_ff <= final_cand.hit ? final_cand.index : '0;
         rbits_ff <= (final_cand.hit && ctl_ff.is_read) ? final_cand.bits : '0;
         rlen_ff  <= (final_cand.hit && ctl_ff.is_read) ? final_cand.len : '0;
      end
   end

   // status and count are settled at accept and stay put until the next word
   logic [1:0]       status_ff;
   logic [CNT_W-1:0] used_ff;

   always_ff @(posedge clock) begin
      if (load_out) begin
         status_ff <= ctl_ff.status;
         used_ff   <= ctl_ff.count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_match_index  = index_ff;
   assign rsp_read_bits    = rbits_ff;
   assign rsp_read_length  = rlen_ff;
   assign rsp_status       = status_ff;
   assign rsp_entries_used = used_ff;

endmodule

// ===== hw/rtl/opmt_cell.sv =====
// opmt_cell: one slot of the table; compares against the broadcast key and
// takes its next contents from the command or from a neighbour
// depends on opmt_pkg
module opmt_cell import opmt_pkg::*; (
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] cell_index,
   input  slot_type         left_slot,
   input  slot_type         right_slot,
   output slot_type         slot,
   output cand_type         cand
);

   slot_type slot_ff, slot_in;
   cand_type cand_ff, cand_in;

   logic [CNT_W-1:0] idx_c;
   logic [CNT_W-1:0] pos_c;
   logic             occupied;
   logic             key_hit;
   slot_type         new_slot;
   slot_type         pad_slot;

   always_comb begin
      idx_c    = CNT_W'(cell_index);
      pos_c    = CNT_W'(cmd.pos);
      occupied = idx_c < cmd.count;
      key_hit  = (cmd.key & lead_mask(slot_ff.len)) == slot_ff.bits;

      new_slot.bits  = cmd.key & lead_mask(cmd.klen);
      new_slot.len   = cmd.klen;
      new_slot.valid = 1'b1;
      pad_slot       = '0;

      slot_in     = slot_ff;
      cand_in.hit = 1'b0;
      case (cmd.kind)
         CMD_SEARCH: begin
            cand_in.hit = occupied && slot_ff.valid && (slot_ff.len <= cmd.klen) && key_hit;
         end
         CMD_EXACT: begin
            cand_in.hit = occupied && slot_ff.valid && (slot_ff.len == cmd.klen) && key_hit;
         end
         CMD_READ: begin
            cand_in.hit = slot_ff.valid && (idx_c == pos_c);
         end
         CMD_WRITE: begin
            if (idx_c == pos_c) slot_in = new_slot;
         end
         CMD_SHIFT_IN: begin
            if (idx_c == pos_c) slot_in = new_slot;
            else if (idx_c > pos_c) slot_in = left_slot;
         end
         CMD_APPEND: begin
            if (idx_c == pos_c) slot_in = new_slot;
            else if (idx_c >= cmd.count && idx_c < pos_c) slot_in = pad_slot;
         end
         CMD_CLEAR: begin
            if (idx_c == pos_c) slot_in.valid = 1'b0;
         end
         CMD_SHIFT_OUT: begin
            if (idx_c >= pos_c) slot_in = right_slot;
         end
         default: ;
      endcase
      cand_in.index = cell_index;
      cand_in.bits  = slot_ff.bits;
      cand_in.len   = slot_ff.len;
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         slot_ff <= slot_in;
         cand_ff <= cand_in;
      end
   end

   assign slot = slot_ff;
   assign cand = cand_ff;

endmodule

// ===== hw/rtl/opmt_pick.sv =====
// opmt_pick: picks the lowest-placed hit out of one group of candidates,
// one node of the priority tree
// depends on opmt_pkg
module opmt_pick import opmt_pkg::*; (
   input  cand_type cand [GROUP_SIZE],
   output cand_type best
);

   always_comb begin
      best = '0;
      for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
         if (cand[k].hit) best = cand[k];
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for ordered_prefix_match_table, with a scoreboard
// class that models the slot table and checks each response word in order
// depends on opmt_pkg and the ordered_prefix_match_table rtl
module tb_top;
   import opmt_pkg::*;

   localparam logic [2:0] ACT_UNUSED  = 3'd7;
   localparam int         HOLD_CYCLES = 120;
   localparam int         RANDOM_WORDS = 890;
   localparam int         SETTLE      = 4 * (TREE_LEVELS + 2);

   typedef struct {
      logic                   hit;
      logic [IDX_W-1:0]       index;
      logic [ENTRY_WIDTH-1:0] bits;
      logic [LEN_W-1:0]       len;
      logic [1:0]             status;
      logic [CNT_W-1:0]       used;
   } lookup_result_type;

   class table_scoreboard;
      logic [ENTRY_WIDTH-1:0] entry_bits [TABLE_DEPTH];
      logic [LEN_W-1:0]       entry_len  [TABLE_DEPTH];
      bit                     entry_live [TABLE_DEPTH];
      int unsigned            used_slots;
      lookup_result_type      expected_answers [$];
      int unsigned            errors;
      int unsigned            checked;
      int unsigned            hits;
      int unsigned            status_seen [4];

      function new();
         used_slots = 0;
         errors     = 0;
         checked    = 0;
         hits       = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
      endfunction

      // leading n bits set, saturating at the entry width
      static function logic [ENTRY_WIDTH-1:0] lead_ones(int unsigned n);
         if (n == 0) return '0;
         if (n > ENTRY_WIDTH) n = ENTRY_WIDTH;
         return ~({ENTRY_WIDTH{1'b1}} >> n);
      endfunction

      function void put_entry(int unsigned i, logic [ENTRY_WIDTH-1:0] b,
                              logic [LEN_W-1:0] l, bit live);
         entry_bits[i] = b;
         entry_len[i]  = l;
         entry_live[i] = live;
      endfunction

      // update the table for one accepted word and queue the response it gives
      function void apply_action(logic [2:0] act, logic [ENTRY_WIDTH-1:0] key,
                                 logic [LEN_W-1:0] klen, logic [IDX_W-1:0] pos);
         lookup_result_type r;
         int unsigned       i;
         r = '{hit: 1'b0, index: '0, bits: '0, len: '0, status: ST_OK, used: '0};
         case (act)
            ACT_SEARCH: begin
               for (i = 0; i < used_slots; i++) begin
                  if (entry_live[i] && entry_len[i] <= klen &&
                      (key & lead_ones(entry_len[i])) == entry_bits[i]) begin
                     r.hit   = 1'b1;
                     r.index = IDX_W'(i);
                     break;
                  end
               end
            end
            ACT_EXACT: begin
               for (i = 0; i < used_slots; i++) begin
                  if (entry_live[i] && entry_len[i] == klen &&
                      (key & lead_ones(klen)) == entry_bits[i]) begin
                     r.hit   = 1'b1;
                     r.index = IDX_W'(i);
                     break;
                  end
               end
            end
            ACT_INSERT, ACT_INSERT_SHIFT: begin
               // full check counts only the slots the insert would add
               if (pos < used_slots) begin
                  if (act == ACT_INSERT_SHIFT && used_slots >= TABLE_DEPTH) r.status = ST_FULL;
               end else if (pos >= TABLE_DEPTH) begin
                  r.status = ST_FULL;
               end
               if (r.status == ST_OK && klen > ENTRY_WIDTH) r.status = ST_WIDE;
               if (r.status == ST_OK) begin
                  if (pos < used_slots) begin
                     if (act == ACT_INSERT_SHIFT) begin
                        for (i = used_slots; i > pos; i--)
                           put_entry(i, entry_bits[i-1], entry_len[i-1], entry_live[i-1]);
                        used_slots++;
                     end
                  end else begin
                     for (i = used_slots; i < pos; i++) put_entry(i, '0, '0, 1'b0);
                     used_slots = pos + 1;
                  end
                  put_entry(pos, key & lead_ones(klen), klen, 1'b1);
               end
            end
            ACT_REMOVE: begin
               if (pos < used_slots) entry_live[pos] = 1'b0;
               else r.status = ST_RANGE;
            end
            ACT_REMOVE_SHIFT: begin
               if (pos < used_slots) begin
                  for (i = pos; i + 1 < used_slots; i++)
                     put_entry(i, entry_bits[i+1], entry_len[i+1], entry_live[i+1]);
                  used_slots--;
               end else begin
                  r.status = ST_RANGE;
               end
            end
            ACT_READ: begin
               if (pos >= used_slots) begin
                  r.status = ST_RANGE;
               end else if (entry_live[pos]) begin
                  r.hit   = 1'b1;
                  r.index = pos;
                  r.bits  = entry_bits[pos];
                  r.len   = entry_len[pos];
               end
            end
            default: ;
         endcase
         r.used = CNT_W'(used_slots);
         expected_answers.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic hit, logic [IDX_W-1:0] index,
                                   logic [ENTRY_WIDTH-1:0] bits, logic [LEN_W-1:0] len,
                                   logic [1:0] status, logic [CNT_W-1:0] used);
         lookup_result_type want;
         if (expected_answers.size() == 0) begin
            $error("response word with nothing outstanding");
            errors++;
            return;
         end
         want = expected_answers.pop_front();
         compare_field("hit", want.hit, hit);
         compare_field("match_index", want.index, index);
         compare_field("read_bits", want.bits, bits);
         compare_field("read_length", want.len, len);
         compare_field("status", want.status, status);
         compare_field("entries_used", want.used, used);
         checked++;
         if (want.hit) hits++;
         status_seen[want.status]++;
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [2:0]             req_action;
   logic [ENTRY_WIDTH-1:0] req_key_bits;
   logic [LEN_W-1:0]       req_key_length;
   logic [IDX_W-1:0]       req_position;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_hit;
   logic [IDX_W-1:0]       rsp_match_index;
   logic [ENTRY_WIDTH-1:0] rsp_read_bits;
   logic [LEN_W-1:0]       rsp_read_length;
   logic [1:0]             rsp_status;
   logic [CNT_W-1:0]       rsp_entries_used;

   table_scoreboard board = new();
   bit              calm = 1'b0;
   bit              hold_off_request = 1'b0;
   int unsigned     words_sent = 0;

   ordered_prefix_match_table uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_key_bits     (req_key_bits),
      .req_key_length   (req_key_length),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_match_index  (rsp_match_index),
      .rsp_read_bits    (rsp_read_bits),
      .rsp_read_length  (rsp_read_length),
      .rsp_status       (rsp_status),
      .rsp_entries_used (rsp_entries_used)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_hit, rsp_match_index, rsp_read_bits, rsp_read_length,
                              rsp_status, rsp_entries_used);
   end

   // offer one word, hold it until taken, then maybe leave a gap
   task automatic send_word(logic [2:0] act, logic [ENTRY_WIDTH-1:0] key,
                            logic [LEN_W-1:0] klen, logic [IDX_W-1:0] pos);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_key_bits   <= key;
      req_key_length <= klen;
      req_position   <= pos;
      do @(posedge clock); while (!req_ready);
      board.apply_action(act, key, klen, pos);
      words_sent++;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_for_answers();
      int unsigned spent;
      spent = 0;
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
         spent++;
      end while (board.expected_answers.size() != 0 && spent < 5000);
   endtask

   task automatic send_random();
      int unsigned            pick;
      int unsigned            n;
      int unsigned            p;
      int unsigned            sl;
      logic [2:0]             act;
      logic [ENTRY_WIDTH-1:0] key;
      logic [LEN_W-1:0]       klen;
      n    = board.used_slots;
      pick = $urandom_range(99);
      // keep the table from sitting near full for long
      if (n >= 48 && $urandom_range(2) == 0) pick = 75;
      key  = $urandom();
      if ($urandom_range(9) == 0) klen = LEN_W'($urandom_range(63, 33));
      else klen = LEN_W'($urandom_range(32));
      if (n == 0 || $urandom_range(7) == 0) p = $urandom_range(63);
      else p = $urandom_range(n - 1);
      if (pick < 36) begin
         act = (pick < 22) ? ACT_SEARCH : ACT_EXACT;
         // most searches aim at a stored entry so that they can hit
         if (n != 0 && $urandom_range(3) != 0) begin
            p   = $urandom_range(n - 1);
            sl  = board.entry_len[p];
            key = board.entry_bits[p] | (key & ~table_scoreboard::lead_ones(sl));
            if (act == ACT_EXACT) klen = LEN_W'(sl);
            else if (klen < sl) klen = LEN_W'(sl + $urandom_range(32 - sl));
         end
      end else if (pick < 64) begin
         act = $urandom_range(1) ? ACT_INSERT : ACT_INSERT_SHIFT;
         case ($urandom_range(29))
            0:             p = $urandom_range(63);
            1, 2, 3, 4, 5,
            6, 7, 8:       p = n + $urandom_range(3);
            default:       p = $urandom_range(n);
         endcase
         if (p > 63) p = 63;
      end else if (pick < 72) begin
         act = ACT_REMOVE;
      end else if (pick < 80) begin
         act = ACT_REMOVE_SHIFT;
      end else if (pick < 98) begin
         act = ACT_READ;
      end else begin
         act = ACT_UNUSED;
      end
      send_word(act, key, klen, IDX_W'(p));
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_SEARCH;
      req_key_bits   = '0;
      req_key_length = '0;
      req_position   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: range errors and misses
      send_word(ACT_READ,         32'h0000_0000, 6'd0,  6'd0);
      send_word(ACT_REMOVE,       32'h0000_0000, 6'd0,  6'd0);
      send_word(ACT_REMOVE_SHIFT, 32'hFFFF_FFFF, 6'd32, 6'd0);
      send_word(ACT_SEARCH,       32'hFFFF_FFFF, 6'd32, 6'd0);
      send_word(ACT_EXACT,        32'h0000_0000, 6'd0,  6'd0);
      // append past the end pads with invalid slots
      send_word(ACT_INSERT,       32'hA5A5_A5A5, 6'd32, 6'd3);
      send_word(ACT_READ,         32'h0000_0000, 6'd0,  6'd1);
      send_word(ACT_READ,         32'h0000_0000, 6'd0,  6'd3);
      // zero-length entry over a padding slot matches any key
      send_word(ACT_INSERT,       32'hFFFF_FFFF, 6'd0,  6'd0);
      send_word(ACT_SEARCH,       32'hA5A5_A5A5, 6'd32, 6'd0);
      send_word(ACT_EXACT,        32'hA5A5_A5A5, 6'd32, 6'd0);
      // entries wider than the table
      send_word(ACT_INSERT,       32'h1234_5678, 6'd33, 6'd1);
      send_word(ACT_INSERT_SHIFT, 32'h1234_5678, 6'd63, 6'd2);
      send_word(ACT_INSERT_SHIFT, 32'h8000_0000, 6'd1,  6'd1);
      send_word(ACT_INSERT_SHIFT, 32'h1234_5678, 6'd16, 6'd5);
      send_word(ACT_REMOVE,       32'h0000_0000, 6'd0,  6'd0);
      // long keys: prefix search accepts them, exact search never matches
      send_word(ACT_SEARCH,       32'h1234_FFFF, 6'd63, 6'd0);
      send_word(ACT_EXACT,        32'h1234_0000, 6'd40, 6'd0);
      // pad out to a full table, then a shift insert must be refused
      send_word(ACT_INSERT_SHIFT, 32'hFFFF_FFFF, 6'd32, 6'd63);
      send_word(ACT_INSERT_SHIFT, 32'h5555_5555, 6'd4,  6'd0);
      send_word(ACT_INSERT,       32'h0F0F_0F0F, 6'd8,  6'd10);
      send_word(ACT_SEARCH,       32'h0F00_0000, 6'd8,  6'd0);
      send_word(ACT_REMOVE_SHIFT, 32'h0000_0000, 6'd0,  6'd0);
      send_word(ACT_READ,         32'h0000_0000, 6'd0,  6'd63);
      send_word(ACT_REMOVE,       32'h0000_0000, 6'd0,  6'd63);
      send_word(ACT_UNUSED,       32'hFFFF_FFFF, 6'd63, 6'd63);
      send_word(ACT_READ,         32'h0000_0000, 6'd0,  6'd62);
      wait_for_answers();

      // receiver stalls for a long time while words keep coming
      hold_off_request = 1'b1;
      repeat (30) send_random();
      wait_for_answers();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 300 && i < 450);
         send_random();
         if (i % 200 == 199) wait_for_answers();
      end
      calm = 1'b0;

      wait_for_answers();
      repeat (SETTLE) @(negedge clock);
      if (board.expected_answers.size() != 0) begin
         $error("%0d response words never arrived", board.expected_answers.size());
         board.errors++;
      end
      $display("sent %0d words over every action, checked %0d responses, %0d hits",
               words_sent, board.checked, board.hits);
      $display("status counts: ok %0d, full %0d, too wide %0d, out of range %0d",
               board.status_seen[ST_OK], board.status_seen[ST_FULL],
               board.status_seen[ST_WIDE], board.status_seen[ST_RANGE]);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
